// ----- src/fcme_pkg.sv -----
// Shared types and constants for the fixed-column mnemonic encoder.
// No dependencies; imported by the line buffer, the decoder and the top level.

package fcme_pkg;

    // Only columns 0..12 are ever examined by the decoder; anything later is dropped.
    localparam int LINE_COLS = 13;
    localparam int CNT_W     = $clog2(LINE_COLS + 1);

    typedef logic [CNT_W-1:0] col_cnt_t;

    // One finished line: the stored columns and the saturated character count.
    typedef struct packed {
        logic [LINE_COLS-1:0][7:0] cols;
        col_cnt_t                  count;
    } line_t;

    // Outcome of decoding one line.
    typedef struct packed {
        logic        hit;
        logic [15:0] opcode;
        logic        status;
    } enc_result_t;

endpackage

// ----- src/fcme_line_buf.sv -----
// Line buffer: gathers characters into a column store and hands each complete
// line to the decoder through a snapshot register. Depends on fcme_pkg.

module fcme_line_buf
    import fcme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_char,
    input  logic       line_end,
    input  logic       take,
    output logic       snap_valid,
    output line_t      snap_line
);

    localparam col_cnt_t COL_LIMIT = CNT_W'(LINE_COLS);

    logic [LINE_COLS-1:0][7:0] store_reg, store_next;
    col_cnt_t                  count_reg, count_next;
    logic                      snap_valid_reg, snap_valid_next;
    line_t                     snap_line_reg;

    logic [LINE_COLS-1:0][7:0] merged;
    col_cnt_t                  count_inc;
    logic                      accept;

    assign in_ready = !snap_valid_reg || take;
    assign accept   = in_valid && in_ready;

    // Current line with the incoming character placed at its column.
    always_comb
    begin
        merged = store_reg;
        if (count_reg < COL_LIMIT)
        begin
            merged[count_reg] = text_char;
        end
        count_inc = (count_reg < COL_LIMIT) ? count_reg + 1'b1 : count_reg;
    end

    always_comb
    begin
        store_next      = store_reg;
        count_next      = count_reg;
        snap_valid_next = snap_valid_reg;
        if (take)
        begin
            snap_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (line_end)
            begin
                store_next      = '0;
                count_next      = '0;
                snap_valid_next = 1'b1;
            end
            else
            begin
                store_next = merged;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg      <= '0;
            count_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg      <= store_next;
            count_reg      <= count_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && line_end)
        begin
            snap_line_reg <= '{cols: merged, count: count_inc};
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_line  = snap_line_reg;

endmodule

// ----- src/fcme_decode.sv -----
// Decoder: matches the mnemonic and operand letters at fixed columns of one
// line and builds the 16-bit opcode. Purely combinational. Depends on fcme_pkg.

module fcme_decode
    import fcme_pkg::*;
(
    input  line_t       line,
    output enc_result_t result
);

    // Top nibbles
    localparam logic [3:0] GRP_SYS     = 4'h0;
    localparam logic [3:0] GRP_JP      = 4'h1;
    localparam logic [3:0] GRP_CALL    = 4'h2;
    localparam logic [3:0] GRP_SE_IMM  = 4'h3;
    localparam logic [3:0] GRP_SNE_IMM = 4'h4;
    localparam logic [3:0] GRP_SE_REG  = 4'h5;
    localparam logic [3:0] GRP_LD_IMM  = 4'h6;
    localparam logic [3:0] GRP_ADD_IMM = 4'h7;
    localparam logic [3:0] GRP_ALU     = 4'h8;
    localparam logic [3:0] GRP_SNE_REG = 4'h9;
    localparam logic [3:0] GRP_LD_I    = 4'hA;
    localparam logic [3:0] GRP_JP_V0   = 4'hB;
    localparam logic [3:0] GRP_RND     = 4'hC;
    localparam logic [3:0] GRP_DRW     = 4'hD;
    localparam logic [3:0] GRP_KEY     = 4'hE;
    localparam logic [3:0] GRP_MISC    = 4'hF;

    // ALU low nibbles
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SUBN = 4'h7;

    // Low bytes
    localparam logic [7:0] LOW_CLS   = 8'hE0;
    localparam logic [7:0] LOW_RET   = 8'hEE;
    localparam logic [7:0] LOW_GETDT = 8'h07;
    localparam logic [7:0] LOW_WKEY  = 8'h0A;
    localparam logic [7:0] LOW_LDMEM = 8'h65;
    localparam logic [7:0] LOW_SETDT = 8'h15;
    localparam logic [7:0] LOW_SETST = 8'h18;
    localparam logic [7:0] LOW_FONT  = 8'h29;
    localparam logic [7:0] LOW_BCD   = 8'h33;
    localparam logic [7:0] LOW_STMEM = 8'h55;
    localparam logic [7:0] LOW_ADDI  = 8'h1E;
    localparam logic [7:0] LOW_SHR   = 8'h06;
    localparam logic [7:0] LOW_SHL   = 8'h0E;
    localparam logic [7:0] LOW_SKP   = 8'h9E;
    localparam logic [7:0] LOW_SKNP  = 8'hA1;

    localparam col_cnt_t LDMEM_LEN = CNT_W'(10);

    // Returns {bad, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c inside {[8'h30:8'h39]})
            begin
                d = c - 8'h30;
                hex_val = {1'b0, d[3:0]};
            end
            else if (c inside {[8'h41:8'h46]})
            begin
                d = c - 8'h37;
                hex_val = {1'b0, d[3:0]};
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                d = c - 8'h57;
                hex_val = {1'b0, d[3:0]};
            end
            else
            begin
                hex_val = 5'b1_0000;
            end
        end
    endfunction

    logic [LINE_COLS-1:0][3:0] nib;
    logic [LINE_COLS-1:0]      nbad;
    logic [LINE_COLS-1:0][7:0] c;
    logic [15:0]               w2;
    logic [23:0]               w3;
    logic [31:0]               w4;
    logic [15:0]               op;
    logic                      bad;
    logic                      hit;

    assign c  = line.cols;
    assign w2 = {c[0], c[1]};
    assign w3 = {c[0], c[1], c[2]};
    assign w4 = {c[0], c[1], c[2], c[3]};

    always_comb
    begin
        for (int i = 0; i < LINE_COLS; i++)
        begin
            {nbad[i], nib[i]} = hex_val(c[i]);
        end

        hit = 1'b1;
        op  = '0;
        bad = 1'b0;

        if (w3 == "CLS")
        begin
            op = {8'h00, LOW_CLS};
        end
        else if (w3 == "RET")
        begin
            op = {8'h00, LOW_RET};
        end
        else if (w3 == "SYS")
        begin
            op  = {GRP_SYS, nib[4], nib[5], nib[6]};
            bad = nbad[4] | nbad[5] | nbad[6];
        end
        else if (w2 == "JP")
        begin
            if (c[3] == "V")
            begin
                op  = {GRP_JP_V0, nib[7], nib[8], nib[9]};
                bad = nbad[7] | nbad[8] | nbad[9];
            end
            else
            begin
                op  = {GRP_JP, nib[3], nib[4], nib[5]};
                bad = nbad[3] | nbad[4] | nbad[5];
            end
        end
        else if (w4 == "CALL")
        begin
            op  = {GRP_CALL, nib[5], nib[6], nib[7]};
            bad = nbad[5] | nbad[6] | nbad[7];
        end
        else if (w2 == "SE")
        begin
            if (c[7] == "V")
            begin
                op  = {GRP_SE_REG, nib[4], nib[8], 4'h0};
                bad = nbad[4] | nbad[8];
            end
            else
            begin
                op  = {GRP_SE_IMM, nib[4], nib[7], nib[8]};
                bad = nbad[4] | nbad[7] | nbad[8];
            end
        end
        else if (w3 == "SNE")
        begin
            if (c[8] == "V")
            begin
                op  = {GRP_SNE_REG, nib[5], nib[9], 4'h0};
                bad = nbad[5] | nbad[9];
            end
            else
            begin
                op  = {GRP_SNE_IMM, nib[5], nib[8], nib[9]};
                bad = nbad[5] | nbad[8] | nbad[9];
            end
        end
        else if (w2 == "LD")
        begin
            if (c[3] == "V")
            begin
                if (c[7] == "D")
                begin
                    op  = {GRP_MISC, nib[4], LOW_GETDT};
                    bad = nbad[4];
                end
                else if (c[7] == "K")
                begin
                    op  = {GRP_MISC, nib[4], LOW_WKEY};
                    bad = nbad[4];
                end
                else if (c[7] == "V")
                begin
                    op  = {GRP_ALU, nib[4], nib[8], ALU_MOV};
                    bad = nbad[4] | nbad[8];
                end
                else if (line.count == LDMEM_LEN && c[7] == "[" && c[8] == "I"
                         && c[9] == "]")
                begin
                    op  = {GRP_MISC, nib[4], LOW_LDMEM};
                    bad = nbad[4];
                end
                else
                begin
                    op  = {GRP_LD_IMM, nib[4], nib[7], nib[8]};
                    bad = nbad[4] | nbad[7] | nbad[8];
                end
            end
            else if (c[3] == "D")
            begin
                op  = {GRP_MISC, nib[8], LOW_SETDT};
                bad = nbad[8];
            end
            else if (c[3] == "S")
            begin
                op  = {GRP_MISC, nib[8], LOW_SETST};
                bad = nbad[8];
            end
            else if (c[3] == "F")
            begin
                op  = {GRP_MISC, nib[7], LOW_FONT};
                bad = nbad[7];
            end
            else if (c[3] == "I")
            begin
                op  = {GRP_LD_I, nib[6], nib[7], nib[8]};
                bad = nbad[6] | nbad[7] | nbad[8];
            end
            else if (c[3] == "B")
            begin
                op  = {GRP_MISC, nib[7], LOW_BCD};
                bad = nbad[7];
            end
            else
            begin
                op  = {GRP_MISC, nib[9], LOW_STMEM};
                bad = nbad[9];
            end
        end
        else if (w3 == "ADD")
        begin
            if (c[4] == "I")
            begin
                op  = {GRP_MISC, nib[8], LOW_ADDI};
                bad = nbad[8];
            end
            else if (c[8] == "V")
            begin
                op  = {GRP_ALU, nib[5], nib[9], ALU_ADD};
                bad = nbad[5] | nbad[9];
            end
            else
            begin
                op  = {GRP_ADD_IMM, nib[5], nib[8], nib[9]};
                bad = nbad[5] | nbad[8] | nbad[9];
            end
        end
        else if (w2 == "OR")
        begin
            op  = {GRP_ALU, nib[4], nib[8], ALU_OR};
            bad = nbad[4] | nbad[8];
        end
        else if (w3 == "AND")
        begin
            op  = {GRP_ALU, nib[5], nib[9], ALU_AND};
            bad = nbad[5] | nbad[9];
        end
        else if (w3 == "XOR")
        begin
            op  = {GRP_ALU, nib[5], nib[9], ALU_XOR};
            bad = nbad[5] | nbad[9];
        end
        else if (w4 == "SUBN")
        begin
            op  = {GRP_ALU, nib[6], nib[10], ALU_SUBN};
            bad = nbad[6] | nbad[10];
        end
        else if (w3 == "SUB")
        begin
            op  = {GRP_ALU, nib[5], nib[9], ALU_SUB};
            bad = nbad[5] | nbad[9];
        end
        else if (w3 == "SHR")
        begin
            op  = {GRP_ALU, nib[5], LOW_SHR};
            bad = nbad[5];
        end
        else if (w3 == "SHL")
        begin
            op  = {GRP_ALU, nib[5], LOW_SHL};
            bad = nbad[5];
        end
        else if (w3 == "RND")
        begin
            op  = {GRP_RND, nib[5], nib[8], nib[9]};
            bad = nbad[5] | nbad[8] | nbad[9];
        end
        else if (w3 == "DRW")
        begin
            op  = {GRP_DRW, nib[5], nib[9], nib[12]};
            bad = nbad[5] | nbad[9] | nbad[12];
        end
        else if (w3 == "SKP")
        begin
            op  = {GRP_KEY, nib[5], LOW_SKP};
            bad = nbad[5];
        end
        else if (w4 == "SKNP")
        begin
            op  = {GRP_KEY, nib[6], LOW_SKNP};
            bad = nbad[6];
        end
        else
        begin
            hit = 1'b0;
        end
    end

    assign result = '{hit: hit, opcode: bad ? 16'h0000 : op, status: bad};

endmodule

// ----- src/fixed_column_mnemonic_encoder.sv -----
// Top level of the fixed-column mnemonic encoder: line buffer, decoder and
// output register. Depends on fcme_pkg, fcme_line_buf and fcme_decode.

// One character is taken per cycle on the slave side while s_tready is high.
// The transaction with tlast closes the line and copies it into the snapshot
// register at the same edge. The decoder works on the snapshot, and its result
// is loaded into the output register once the output stage can take it.
// Lines may follow each other with no gap: throughput is one character per
// cycle, limited only by back-pressure on the master side. Only columns 0 to
// 12 take part in decoding; later characters are dropped. A line whose
// mnemonic is not recognised yields no transaction. A bad or missing hex digit
// yields opcode zero with the status flag set.

module fixed_column_mnemonic_encoder
    import fcme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] opcode
    output logic        m_tuser    // [0] status
);

    logic        snap_valid;
    line_t       snap_line;
    enc_result_t res;
    logic        take;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] opcode_reg;
    logic        status_reg;

    assign take = !out_valid_reg || m_tready;

    fcme_line_buf u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .text_char  (s_tdata),
        .line_end   (s_tlast),
        .take       (take),
        .snap_valid (snap_valid),
        .snap_line  (snap_line)
    );

    fcme_decode u_decode (
        .line   (snap_line),
        .result (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (snap_valid && take)
        begin
            out_valid_next = res.hit;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && take)
        begin
            opcode_reg <= res.opcode;
            status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = opcode_reg;
    assign m_tuser  = status_reg;

    // An error result always carries a zero opcode
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'h0000)
        else $error("error result with non-zero opcode");

    // A fresh result only follows a line held in the snapshot
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(snap_valid))
        else $error("result appeared without a decoded line");

    // Input back-pressure only while a line waits for the output stage
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> snap_valid && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

    // A waiting snapshot is not overwritten
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && !take |=> snap_valid && $stable(snap_line))
        else $error("snapshot changed while stalled");

endmodule
